[sv/cle_pkg.sv]
package cle_pkg;

    // Line store geometry.
    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

    // Destination codes of a result item.
    localparam logic [1:0] DEST_TERM = 2'd0;
    localparam logic [1:0] DEST_CMD  = 2'd1;
    localparam logic [1:0] DEST_END  = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_DEL  = 8'h7f;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_LBR  = 8'h5b;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_K    = 8'h4b;
    localparam logic [7:0] CH_GT   = 8'h3e;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // Final step numbers of the fixed byte sequences.
    localparam logic [2:0] BS_LAST   = 3'd5;
    localparam logic [2:0] CRLF_LAST = 3'd1;
    localparam logic [2:0] TAIL_LAST = 3'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_BS,
        ST_CRLF,
        ST_CMD,
        ST_TAIL
    } ctl_state_t;

    // One result item offered by the sequencer to the output register.
    typedef struct packed {
        logic       valid;
        logic [1:0] dest;
        logic [7:0] data_byte;
        logic       last;
    } emit_t;

    // True for an ASCII letter, which ends an escape sequence.
    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    // Cursor-left then erase-to-end-of-line.
    function automatic logic [7:0] bs_byte(logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = CH_ESC;
            3'd1:    b = CH_LBR;
            3'd2:    b = CH_D;
            3'd3:    b = CH_ESC;
            3'd4:    b = CH_LBR;
            default: b = CH_K;
        endcase
        return b;
    endfunction

endpackage

[sv/cle_rx_if.sv]
interface cle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[sv/cle_tx_if.sv]
interface cle_tx_if;
    logic       valid;
    logic       ready;
    logic [1:0] dest;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output dest, output data_byte, output last, input ready);
    modport sink   (input valid, input dest, input data_byte, input last, output ready);
endinterface

[sv/cle_ram.sv]
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[sv/cle_ctrl.sv]
module cle_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    cle_rx_if.sink                      rx,
    input  logic                        slot_free,
    output cle_pkg::emit_t              emit,
    output logic                        ram_we,
    output logic [cle_pkg::ADDR_W-1:0]  ram_waddr,
    output logic [7:0]                  ram_wdata,
    output logic [cle_pkg::ADDR_W-1:0]  ram_raddr,
    input  logic [7:0]                  ram_rdata
);

    cle_pkg::ctl_state_t            state_reg, state_next;
    logic [2:0]                     step_reg, step_next;
    logic [cle_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [cle_pkg::LEN_W-1:0]      idx_reg, idx_next;
    logic                           esc_reg, esc_next;
    logic [7:0]                     echo_reg, echo_next;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cle_pkg::ST_IDLE;
            step_reg  <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            esc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            esc_reg   <= esc_next;
        end
    end

    // The byte to be echoed needs no reset.
    always_ff @(posedge clk)
    begin
        echo_reg <= echo_next;
    end

    // Sequencer: decodes an item in idle, then steps through its results one per free slot.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        esc_next   = esc_reg;
        echo_next  = echo_reg;
        emit       = '0;
        ram_we     = 1'b0;
        ram_waddr  = len_reg[cle_pkg::ADDR_W-1:0];
        ram_wdata  = rx.rx_byte;
        rx.ready   = (state_reg == cle_pkg::ST_IDLE);

        case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                if (rx.valid)
                begin
                    step_next = '0;
                    if (esc_reg)
                    begin
                        if (cle_pkg::is_letter(rx.rx_byte))
                        begin
                            esc_next = 1'b0;
                        end
                    end
                    else if (rx.rx_byte == cle_pkg::CH_CR)
                    begin
                        state_next = cle_pkg::ST_CRLF;
                    end
                    else if (rx.rx_byte == cle_pkg::CH_DEL)
                    begin
                        if (len_reg != '0)
                        begin
                            len_next   = len_reg - 1'b1;
                            state_next = cle_pkg::ST_BS;
                        end
                    end
                    else if (rx.rx_byte == cle_pkg::CH_ESC)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (len_reg < cle_pkg::LEN_W'(cle_pkg::LINE_DEPTH))
                    begin
                        ram_we     = 1'b1;
                        len_next   = len_reg + 1'b1;
                        echo_next  = rx.rx_byte;
                        state_next = cle_pkg::ST_ECHO;
                    end
                end
            end

            cle_pkg::ST_ECHO:
            begin
                if (slot_free)
                begin
                    emit       = '{1'b1, cle_pkg::DEST_TERM, echo_reg, 1'b1};
                    state_next = cle_pkg::ST_IDLE;
                end
            end

            cle_pkg::ST_BS:
            begin
                if (slot_free)
                begin
                    emit = '{1'b1, cle_pkg::DEST_TERM, cle_pkg::bs_byte(step_reg),
                             step_reg == cle_pkg::BS_LAST};
                    step_next = step_reg + 1'b1;
                    if (step_reg == cle_pkg::BS_LAST)
                    begin
                        state_next = cle_pkg::ST_IDLE;
                    end
                end
            end

            cle_pkg::ST_CRLF:
            begin
                // Start the store read at the first entry.
                idx_next = '0;
                if (slot_free)
                begin
                    emit = '{1'b1, cle_pkg::DEST_TERM,
                             (step_reg == '0) ? cle_pkg::CH_CR : cle_pkg::CH_LF, 1'b0};
                    step_next = step_reg + 1'b1;
                    if (step_reg == cle_pkg::CRLF_LAST)
                    begin
                        step_next  = '0;
                        state_next = cle_pkg::ST_CMD;
                    end
                end
            end

            cle_pkg::ST_CMD:
            begin
                // The command ends at the line length or at the first stored zero byte.
                if ((idx_reg >= len_reg) || (ram_rdata == cle_pkg::CH_NUL))
                begin
                    len_next   = '0;
                    state_next = cle_pkg::ST_TAIL;
                end
                else if (slot_free)
                begin
                    emit     = '{1'b1, cle_pkg::DEST_CMD, ram_rdata, 1'b0};
                    idx_next = idx_reg + 1'b1;
                end
            end

            cle_pkg::ST_TAIL:
            begin
                if (slot_free)
                begin
                    case (step_reg)
                        3'd0:    emit = '{1'b1, cle_pkg::DEST_END, cle_pkg::CH_NUL, 1'b0};
                        3'd1:    emit = '{1'b1, cle_pkg::DEST_TERM, cle_pkg::CH_GT, 1'b0};
                        default: emit = '{1'b1, cle_pkg::DEST_TERM, cle_pkg::CH_SP, 1'b1};
                    endcase
                    step_next = step_reg + 1'b1;
                    if (step_reg == cle_pkg::TAIL_LAST)
                    begin
                        state_next = cle_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = cle_pkg::ST_IDLE;
            end
        endcase

        // The read address follows the next index, so data lines up with idx_reg.
        ram_raddr = idx_next[cle_pkg::ADDR_W-1:0];
    end

    // The line never grows beyond the store.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= cle_pkg::LEN_W'(cle_pkg::LINE_DEPTH))
        else $error("line length beyond store depth");

    // A command byte is only read from a written entry.
    a_cmd_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && (emit.dest == cle_pkg::DEST_CMD)) |-> (idx_reg < len_reg))
        else $error("command byte read beyond line length");

    // The final result of an item returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.last) |=> (state_reg == cle_pkg::ST_IDLE))
        else $error("sequencer not idle after final result");

    // The line is already cleared while the prompt goes out.
    a_tail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cle_pkg::ST_TAIL) |-> (len_reg == '0))
        else $error("line not cleared after carriage return");

    // Results are only offered into a free output slot.
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> slot_free)
        else $error("result offered into a busy output register");

endmodule

[sv/console_line_editor_top.sv]
// Console line editor.
//
// The rx channel carries one terminal byte per item; the tx channel carries the
// result items: a byte for the terminal, a command byte or the command end
// marker, with last set on the final result that an input item causes.
// Both channels use a valid/ready handshake; an item moves when both are high.
//
// The block works on one input item at a time: rx.ready is high only while the
// sequencer is idle. An accepted byte is stored and passes through the echo
// state into the output register for tx; the sequencer is then idle again and
// can take the next item. Backspace gives six results, one per cycle while the
// output register is free. A carriage return gives n + 5 results for a command
// of n bytes: the line store is read one entry per cycle through its registered
// read port while the output register is free, the first read being started
// with the line feed, and the end of the line is seen in a step with no result.
// Escapes, an empty-line backspace and a byte into a full line give no result
// and leave the sequencer idle.
// A result waits in the output register while tx.ready is low; the sequencer
// then holds its place. Reset clears the line length and the escape flag; the
// line store itself holds no reset value and is only read where written.
module console_line_editor_top (
    input  logic      clk,
    input  logic      rst_n,
    cle_rx_if.sink    rx,
    cle_tx_if.source  tx
);

    cle_pkg::emit_t                 emit;
    logic                           slot_free;
    logic                           ram_we;
    logic [cle_pkg::ADDR_W-1:0]     ram_waddr;
    logic [7:0]                     ram_wdata;
    logic [cle_pkg::ADDR_W-1:0]     ram_raddr;
    logic [7:0]                     ram_rdata;

    logic                           out_valid_reg, out_valid_next;
    logic [1:0]                     out_dest_reg;
    logic [7:0]                     out_data_reg;
    logic                           out_last_reg;

    cle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .slot_free (slot_free),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    cle_ram #(
        .WIDTH (8),
        .DEPTH (cle_pkg::LINE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register is free when empty or when its item leaves this cycle.
    assign slot_free = !out_valid_reg || tx.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the output register.
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_dest_reg <= emit.dest;
            out_data_reg <= emit.data_byte;
            out_last_reg <= emit.last;
        end
    end

    assign tx.valid     = out_valid_reg;
    assign tx.dest      = out_dest_reg;
    assign tx.data_byte = out_data_reg;
    assign tx.last      = out_last_reg;

endmodule

[sim/tb_console_line_editor_top.sv]
module tb_console_line_editor_top;

    // One result item as it is seen on the tx channel.
    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] data_byte;
        logic       last;
    } tx_item_t;

    // Ways in which the receiver holds off the tx channel.
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_EVERY8,
        RDY_RUNS
    } stall_mode_t;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          SETTLE_TICKS = 50;
    localparam int          RANDOM_ITEMS = 220;

    logic clk = 1'b0;
    logic rst_n;

    cle_rx_if rx_ch ();
    cle_tx_if tx_ch ();

    console_line_editor_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    // Predicted editor state.
    logic [7:0]  line_copy [cle_pkg::LINE_DEPTH];
    int          line_len;
    logic        esc_active;

    // Results still owed by the block, oldest first.
    tx_item_t    pending_tx [$];

    int          mismatch_count;
    int          sent_items;
    int          burst_left;
    int unsigned cycle_count;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: the pattern is chosen by bits 9:8 of the cycle count.
    always @(posedge clk)
    begin : tx_stall
        stall_mode_t mode;
        mode = stall_mode_t'(cycle_count[9:8]);
        if (!rst_n)
        begin
            tx_ch.ready <= 1'b0;
        end
        else
        begin
            case (mode)
                RDY_ALWAYS: tx_ch.ready <= 1'b1;
                RDY_COIN:   tx_ch.ready <= ($urandom_range(0, 1) != 0);
                RDY_EVERY8: tx_ch.ready <= (cycle_count[2:0] != 3'd0);
                default:    tx_ch.ready <= (cycle_count[4:3] != 2'd0);
            endcase
        end
    end

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // Compare each accepted result with the oldest outstanding one.
    always @(posedge clk)
    begin : check_tx
        tx_item_t want;
        tx_item_t got;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            got = '{tx_ch.dest, tx_ch.data_byte, tx_ch.last};
            if (pending_tx.size() == 0)
            begin
                flag_error($sformatf("unexpected result: dest %0d byte %02h last %0b",
                                     got.dest, got.data_byte, got.last));
            end
            else
            begin
                want = pending_tx.pop_front();
                if (got !== want)
                begin
                    flag_error($sformatf(
                        "mismatch: want dest %0d byte %02h last %0b, got %0d %02h %0b",
                        want.dest, want.data_byte, want.last,
                        got.dest, got.data_byte, got.last));
                end
            end
        end
    end

    // Apply one received byte to the predicted editor and queue its results.
    // Returns the number of results the byte causes.
    function automatic int apply_rx_byte(input logic [7:0] c);
        tx_item_t outs [$];
        int       i;
        if (esc_active)
        begin
            // Only a letter closes the escape sequence.
            if (((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a)))
            begin
                esc_active = 1'b0;
            end
        end
        else if (c == cle_pkg::CH_CR)
        begin
            outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_CR, 1'b0});
            outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_LF, 1'b0});
            // The command stops short of the first stored zero byte.
            for (i = 0; i < line_len; i++)
            begin
                if (line_copy[cle_pkg::ADDR_W'(i)] == cle_pkg::CH_NUL)
                begin
                    break;
                end
                outs.push_back('{cle_pkg::DEST_CMD, line_copy[cle_pkg::ADDR_W'(i)], 1'b0});
            end
            outs.push_back('{cle_pkg::DEST_END, cle_pkg::CH_NUL, 1'b0});
            outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_GT, 1'b0});
            outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_SP, 1'b0});
            line_len = 0;
        end
        else if (c == cle_pkg::CH_DEL)
        begin
            if (line_len > 0)
            begin
                line_len--;
                outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_ESC, 1'b0});
                outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_LBR, 1'b0});
                outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_D, 1'b0});
                outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_ESC, 1'b0});
                outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_LBR, 1'b0});
                outs.push_back('{cle_pkg::DEST_TERM, cle_pkg::CH_K, 1'b0});
            end
        end
        else if (c == cle_pkg::CH_ESC)
        begin
            esc_active = 1'b1;
        end
        else if (line_len < cle_pkg::LINE_DEPTH)
        begin
            // Ordinary byte: stored and echoed; dropped when the line is full.
            line_copy[cle_pkg::ADDR_W'(line_len)] = c;
            line_len++;
            outs.push_back('{cle_pkg::DEST_TERM, c, 1'b0});
        end
        if (outs.size() > 0)
        begin
            outs[outs.size() - 1].last = 1'b1;
        end
        foreach (outs[k])
        begin
            pending_tx.push_back(outs[k]);
        end
        return outs.size();
    endfunction

    // Send one byte, with random gaps between bursts of items.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        sent_items++;
        void'(apply_rx_byte(b));
    endtask

    // Stop sending until every outstanding result has arrived.
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_tx.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Any byte that is stored and echoed, never zero.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while ((b == cle_pkg::CH_CR) || (b == cle_pkg::CH_DEL) || (b == cle_pkg::CH_ESC));
        return b;
    endfunction

    function automatic logic [7:0] any_letter();
        if ($urandom_range(0, 1) != 0)
        begin
            return 8'($urandom_range(8'h41, 8'h5a));
        end
        return 8'($urandom_range(8'h61, 8'h7a));
    endfunction

    // Echo, a zero byte inside the line, and a command cut at that zero.
    task automatic test_echo_and_command();
        send_byte(8'h41);
        send_byte(cle_pkg::CH_NUL);
        send_byte(8'h7a);
        send_byte(cle_pkg::CH_CR);
        wait_drained();
    endtask

    // Backspace on an empty and a non-empty line, and the top byte values.
    task automatic test_backspace();
        send_byte(cle_pkg::CH_DEL);
        send_byte(8'h78);
        send_byte(cle_pkg::CH_DEL);
        send_byte(cle_pkg::CH_DEL);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(cle_pkg::CH_CR);
        wait_drained();
    endtask

    // Escape sequences: the neighbours of the letter ranges, ESC, CR and
    // backspace are all swallowed; upper and lower case letters end it.
    task automatic test_escape();
        send_byte(cle_pkg::CH_ESC);
        send_byte(8'h40);
        send_byte(8'h5b);
        send_byte(8'h60);
        send_byte(8'h7b);
        send_byte(cle_pkg::CH_ESC);
        send_byte(cle_pkg::CH_CR);
        send_byte(cle_pkg::CH_DEL);
        send_byte(8'h5a);
        send_byte(cle_pkg::CH_ESC);
        send_byte(8'h61);
        send_byte(8'h71);
        send_byte(cle_pkg::CH_CR);
        wait_drained();
    endtask

    // A full line: overflow bytes are dropped, backspace frees one place,
    // and a full command gives the longest run of results.
    task automatic test_full_line();
        int zero_pos;
        repeat (cle_pkg::LINE_DEPTH) send_byte(plain_byte());
        send_byte(plain_byte());
        send_byte(cle_pkg::CH_DEL);
        send_byte(plain_byte());
        send_byte(plain_byte());
        send_byte(cle_pkg::CH_CR);
        // A second full line with a zero byte somewhere in it.
        zero_pos = $urandom_range(0, cle_pkg::LINE_DEPTH - 1);
        for (int i = 0; i < cle_pkg::LINE_DEPTH; i++)
        begin
            send_byte((i == zero_pos) ? cle_pkg::CH_NUL : plain_byte());
        end
        send_byte(cle_pkg::CH_CR);
        wait_drained();
    endtask

    // Mostly well-formed lines with random content and edits, some noise.
    task automatic test_random();
        int  start_count;
        int  len;
        int  pick;
        bit  paused;
        start_count = sent_items;
        paused      = 1'b0;
        while (sent_items - start_count < RANDOM_ITEMS)
        begin
            if (!paused && (sent_items - start_count >= RANDOM_ITEMS / 2))
            begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36)
                                                 : $urandom_range(0, 12);
                for (int i = 0; i < len; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                    begin
                        send_byte(cle_pkg::CH_DEL);
                    end
                    else if (pick < 13)
                    begin
                        send_byte(cle_pkg::CH_ESC);
                        if ($urandom_range(0, 1) != 0)
                        begin
                            send_byte(cle_pkg::CH_LBR);
                        end
                        repeat ($urandom_range(0, 2))
                            send_byte(8'($urandom_range(8'h30, 8'h39)));
                        send_byte(any_letter());
                    end
                    else if (pick < 16)
                    begin
                        send_byte(cle_pkg::CH_NUL);
                    end
                    else
                    begin
                        send_byte(plain_byte());
                    end
                end
                send_byte(cle_pkg::CH_CR);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'h00;
        tx_ch.ready    = 1'b0;
        line_len       = 0;
        esc_active     = 1'b0;
        mismatch_count = 0;
        sent_items     = 0;
        burst_left     = 0;
        cycle_count    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_echo_and_command();
        test_backspace();
        test_escape();
        test_full_line();
        test_random();

        // Let the last results arrive, then allow for any stray ones.
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (pending_tx.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", pending_tx.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
